/* rtl/tsrr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared types, codes and helpers for the thread slot table.
// ----------------------------------------------------------------------------
package tsrr_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_DESTROY = 3'd1;
	localparam logic [2:0] CMD_PICK    = 3'd2;
	localparam logic [2:0] CMD_SWITCH  = 3'd3;
	localparam logic [2:0] CMD_ENTER   = 3'd4;
	localparam logic [2:0] CMD_SETST   = 3'd5;

	localparam logic [2:0] ST_UNUSED  = 3'd0;
	localparam logic [2:0] ST_RUNNING = 3'd1;
	localparam logic [2:0] ST_READY   = 3'd2;

	localparam logic [1:0] RS_OK       = 2'd0;
	localparam logic [1:0] RS_NOSLOT   = 2'd1;
	localparam logic [1:0] RS_NOTFOUND = 2'd2;
	localparam logic [1:0] RS_REFUSED  = 2'd3;

	typedef struct packed {
		logic [2:0]  state;
		logic        entered;
		logic [31:0] pid;
		logic [31:0] gen;
	} entry_t;

	typedef struct packed {
		logic   en;
		idx_t   addr;
		entry_t data;
	} wr_req_t;

	function automatic idx_t next_idx(idx_t i);
		idx_t r;
		if (i == idx_t'(SLOT_COUNT - 1)) begin
			r = '0;
		end else begin
			r = i + idx_t'(1);
		end
		return r;
	endfunction

	function automatic logic [3:0] slot_field(idx_t i);
		logic [IDX_W+3:0] w;
		w = {{4{1'b0}}, i};
		return w[3:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/tsrr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsrr_cmd_if / tsrr_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface tsrr_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [31:0] req_pid;
	logic [2:0]  new_state;

	modport source(output valid, command, req_pid, new_state, input ready);
	modport sink(input valid, command, req_pid, new_state, output ready);
endinterface

interface tsrr_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_pid;
	logic [3:0]  result_slot;
	logic [31:0] result_generation;

	modport source(output valid, status, result_pid, result_slot, result_generation,
		input ready);
	modport sink(input valid, status, result_pid, result_slot, result_generation,
		output ready);
endinterface
`default_nettype wire

/* rtl/tsrr_slot_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsrr_slot_store
// Slot entry memory, one read and one write port, registered read data.
// Per-entry valid bits stand in for the reset contents.
// ----------------------------------------------------------------------------
module tsrr_slot_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire tsrr_pkg::idx_t    rd_addr,
	output tsrr_pkg::entry_t       rd_data,
	input  wire tsrr_pkg::wr_req_t wr
);

	tsrr_pkg::entry_t                  mem [tsrr_pkg::SLOT_COUNT];
	logic [tsrr_pkg::SLOT_COUNT-1:0]   valid_q;
	tsrr_pkg::entry_t                  data_s1;
	logic                              valid_s1;
	logic                              zero_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			data_s1  <= mem[rd_addr];
			valid_s1 <= valid_q[rd_addr];
			zero_s1  <= (rd_addr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_comb begin
		if (valid_s1) begin
			rd_data = data_s1;
		end else begin
			rd_data       = '0;
			rd_data.state = zero_s1 ? tsrr_pkg::ST_RUNNING : tsrr_pkg::ST_UNUSED;
		end
	end

endmodule
`default_nettype wire

/* rtl/thread_slot_table_round_robin.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thread_slot_table_round_robin
// Thread slot table with create, destroy, round-robin pick and switch.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word (command, req_pid, new_state); res returns
//   exactly one result word per command (status, result_pid, result_slot,
//   result_generation). A word moves when valid and ready are both high.
//   Slot entries live in a single-port-read, single-port-write memory. Each
//   command sweeps all SLOT_COUNT entries, one read per cycle, then, for a
//   create, destroy, enter, set-state or switch that succeeds, writes back
//   the target entry and, for a switch, demotes the old running entry. The
//   time from command accept to result valid is set by the memory read
//   sweep, and is longer for a switch that demotes a running thread.
//   cmd.ready is high only between commands and returns the cycle after the
//   result is loaded, so no new command is taken before that.
//   After reset slot 0 is the running idle thread, all other slots are free,
//   the current slot is 0 and the next pid is 1; no clearing pass is needed.
//   The result register holds a word while res.ready is low; the next
//   command may be accepted meanwhile, and its result waits until the
//   register frees.
// ----------------------------------------------------------------------------
module thread_slot_table_round_robin (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsrr_cmd_if.sink    cmd,
	tsrr_res_if.source  res
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_LAST   = 3'd2;
	localparam logic [2:0] S_EXEC   = 3'd3;
	localparam logic [2:0] S_DEMOTE = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        cmd_q;
	logic [31:0]       tpid_q;
	logic [2:0]        nst_q;
	tsrr_pkg::idx_t    addr_q;
	tsrr_pkg::idx_t    cnt_q;
	tsrr_pkg::idx_t    cur_q;
	logic [31:0]       pidctr_q;

	logic              rd_v_s1;
	tsrr_pkg::idx_t    rd_idx_s1;
	tsrr_pkg::entry_t  rd_ent;

	logic              found_q;
	tsrr_pkg::idx_t    fidx_q;
	tsrr_pkg::entry_t  fent_q;
	tsrr_pkg::entry_t  curent_q;
	logic [31:0]       gen0_q;
	tsrr_pkg::idx_t    dem_idx_q;

	logic [1:0]        rstat_q;
	logic [31:0]       rpid_q;
	logic [3:0]        rslot_q;
	logic [31:0]       rgen_q;

	logic              ovalid_q;
	logic [1:0]        ostat_q;
	logic [31:0]       opid_q;
	logic [3:0]        oslot_q;
	logic [31:0]       ogen_q;

	logic              rd_en;
	logic              match;
	tsrr_pkg::wr_req_t wr;
	tsrr_pkg::wr_req_t ex_wr;
	logic [1:0]        ex_stat;
	logic [31:0]       ex_pid;
	logic [3:0]        ex_slot;
	logic [31:0]       ex_gen;
	logic              ex_demote;
	logic              ex_move;
	logic              ex_bump;
	logic [31:0]       new_gen;
	logic              accept;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign rd_en = (state_q == S_SCAN);

	assign res.valid             = ovalid_q;
	assign res.status            = ostat_q;
	assign res.result_pid        = opid_q;
	assign res.result_slot       = oslot_q;
	assign res.result_generation = ogen_q;

	tsrr_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_ent),
		.wr      (wr)
	);

	always_comb begin
		unique case (cmd_q)
			tsrr_pkg::CMD_CREATE: begin
				match = (rd_idx_s1 != '0) && (rd_ent.state == tsrr_pkg::ST_UNUSED);
			end
			tsrr_pkg::CMD_DESTROY, tsrr_pkg::CMD_SWITCH,
			tsrr_pkg::CMD_ENTER, tsrr_pkg::CMD_SETST: begin
				match = (rd_ent.pid == tpid_q) && (rd_ent.state != tsrr_pkg::ST_UNUSED);
			end
			tsrr_pkg::CMD_PICK: begin
				match = (rd_ent.state == tsrr_pkg::ST_READY) && (rd_ent.pid != '0)
					&& rd_ent.entered;
			end
			default: begin
				match = 1'b0;
			end
		endcase
	end

	always_comb begin
		new_gen = fent_q.gen + 32'd1;
		if (new_gen == '0) begin
			new_gen = 32'd1;
		end
		ex_wr      = '0;
		ex_wr.addr = fidx_q;
		ex_wr.data = fent_q;
		ex_stat    = tsrr_pkg::RS_OK;
		ex_pid     = tpid_q;
		ex_slot    = '0;
		ex_gen     = '0;
		ex_demote  = 1'b0;
		ex_move    = 1'b0;
		ex_bump    = 1'b0;
		unique case (cmd_q)
			tsrr_pkg::CMD_CREATE: begin
				if (found_q) begin
					ex_wr.en           = 1'b1;
					ex_wr.data.state   = tsrr_pkg::ST_READY;
					ex_wr.data.entered = 1'b0;
					ex_wr.data.pid     = pidctr_q;
					ex_wr.data.gen     = new_gen;
					ex_pid             = pidctr_q;
					ex_slot            = tsrr_pkg::slot_field(fidx_q);
					ex_gen             = new_gen;
					ex_bump            = 1'b1;
				end else begin
					ex_stat = tsrr_pkg::RS_NOSLOT;
					ex_pid  = '0;
				end
			end
			tsrr_pkg::CMD_DESTROY, tsrr_pkg::CMD_ENTER, tsrr_pkg::CMD_SETST: begin
				if (found_q) begin
					ex_wr.en = 1'b1;
					if (cmd_q == tsrr_pkg::CMD_DESTROY) begin
						ex_wr.data.state = tsrr_pkg::ST_UNUSED;
					end else if (cmd_q == tsrr_pkg::CMD_ENTER) begin
						ex_wr.data.entered = 1'b1;
					end else begin
						ex_wr.data.state = nst_q;
					end
					ex_slot = tsrr_pkg::slot_field(fidx_q);
					ex_gen  = fent_q.gen;
				end else begin
					ex_stat = tsrr_pkg::RS_NOTFOUND;
				end
			end
			tsrr_pkg::CMD_PICK: begin
				if (found_q) begin
					ex_pid  = fent_q.pid;
					ex_slot = tsrr_pkg::slot_field(fidx_q);
					ex_gen  = fent_q.gen;
				end else begin
					ex_pid = '0;
					ex_gen = gen0_q;
				end
			end
			tsrr_pkg::CMD_SWITCH: begin
				if (!found_q) begin
					ex_stat = tsrr_pkg::RS_NOTFOUND;
				end else begin
					ex_slot = tsrr_pkg::slot_field(fidx_q);
					ex_gen  = fent_q.gen;
					if ((fent_q.state != tsrr_pkg::ST_READY &&
						fent_q.state != tsrr_pkg::ST_RUNNING) ||
						curent_q.pid == tpid_q) begin
						ex_stat = tsrr_pkg::RS_REFUSED;
					end else begin
						ex_wr.en         = 1'b1;
						ex_wr.data.state = tsrr_pkg::ST_RUNNING;
						ex_demote        = (curent_q.state == tsrr_pkg::ST_RUNNING);
						ex_move          = 1'b1;
					end
				end
			end
			default: begin
				ex_stat = tsrr_pkg::RS_OK;
			end
		endcase
	end

	always_comb begin
		wr = '0;
		if (state_q == S_EXEC) begin
			wr = ex_wr;
		end else if (state_q == S_DEMOTE) begin
			wr.en         = 1'b1;
			wr.addr       = dem_idx_q;
			wr.data       = curent_q;
			wr.data.state = tsrr_pkg::ST_READY;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			cmd_q  <= cmd.command;
			tpid_q <= cmd.req_pid;
			nst_q  <= cmd.new_state;
			cnt_q  <= '0;
			addr_q <= (cmd.command == tsrr_pkg::CMD_PICK) ? tsrr_pkg::next_idx(cur_q) : '0;
		end else if (state_q == S_SCAN) begin
			cnt_q  <= cnt_q + tsrr_pkg::idx_t'(1);
			addr_q <= tsrr_pkg::next_idx(addr_q);
		end
		if (rd_v_s1) begin
			if (match && !found_q) begin
				fidx_q <= rd_idx_s1;
				fent_q <= rd_ent;
			end
			if (rd_idx_s1 == cur_q) begin
				curent_q <= rd_ent;
			end
			if (rd_idx_s1 == '0) begin
				gen0_q <= rd_ent.gen;
			end
		end
		if (state_q == S_EXEC) begin
			rstat_q   <= ex_stat;
			rpid_q    <= ex_pid;
			rslot_q   <= ex_slot;
			rgen_q    <= ex_gen;
			dem_idx_q <= cur_q;
		end
		if (state_q == S_FIN && (!ovalid_q || res.ready)) begin
			ostat_q <= rstat_q;
			opid_q  <= rpid_q;
			oslot_q <= rslot_q;
			ogen_q  <= rgen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			pidctr_q <= 32'd1;
			rd_v_s1  <= 1'b0;
			found_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (rd_v_s1 && match) begin
				found_q <= 1'b1;
			end
			if (ovalid_q && res.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == tsrr_pkg::idx_t'(tsrr_pkg::SLOT_COUNT - 1)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ex_bump) begin
						pidctr_q <= pidctr_q + 32'd1;
					end
					if (ex_move) begin
						cur_q <= fidx_q;
					end
					state_q <= ex_demote ? S_DEMOTE : S_FIN;
				end
				S_DEMOTE: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!ovalid_q || res.ready) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/tsrr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsrr_checker
// Port-level checks for the thread slot table, bound to the top level.
// ----------------------------------------------------------------------------
module tsrr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] result_pid,
	input wire logic [3:0]  result_slot,
	input wire logic [31:0] result_generation
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command word taken during a sweep");

	a_noslot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tsrr_pkg::RS_NOSLOT |->
		result_pid == '0 && result_slot == '0 && result_generation == '0)
		else $error("no-slot result carries nonzero fields");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tsrr_pkg::RS_NOTFOUND |->
		result_slot == '0 && result_generation == '0)
		else $error("not-found result carries a slot");

endmodule

bind thread_slot_table_round_robin tsrr_checker u_tsrr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (cmd.valid),
	.in_ready          (cmd.ready),
	.out_valid         (res.valid),
	.out_ready         (res.ready),
	.status            (res.status),
	.result_pid        (res.result_pid),
	.result_slot       (res.result_slot),
	.result_generation (res.result_generation)
);
`default_nettype wire

/* sim/tb_thread_slot_table_round_robin.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thread_slot_table_round_robin
// Self-checking bench for the thread slot table. Command words go in with
// bursty pacing, and the result side stalls on shifting patterns. A tracker
// class keeps its own copy of the slot table, predicts one result word per
// accepted command, and checks each result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_thread_slot_table_round_robin;

	localparam logic [2:0] CMD_RSVD6  = 3'd6;
	localparam logic [2:0] CMD_RSVD7  = 3'd7;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_CODE7   = 3'd7;

	localparam int RANDOM_ITEMS  = 1750;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_pid;
		logic [3:0]  result_slot;
		logic [31:0] result_generation;
	} res_word_t;

	class slot_table_tracker;
		logic [2:0]  state_q [tsrr_pkg::SLOT_COUNT];
		logic [31:0] pid_q [tsrr_pkg::SLOT_COUNT];
		logic [31:0] gen_q [tsrr_pkg::SLOT_COUNT];
		bit          entered_q [tsrr_pkg::SLOT_COUNT];
		int          cur;
		logic [31:0] pid_ctr;
		res_word_t   expected_words [$];
		res_word_t   last_word;
		int          errors;

		function void reset_table();
			int i;
			for (i = 0; i < tsrr_pkg::SLOT_COUNT; i++) begin
				state_q[i]   = tsrr_pkg::ST_UNUSED;
				pid_q[i]     = '0;
				gen_q[i]     = '0;
				entered_q[i] = 1'b0;
			end
			state_q[0] = tsrr_pkg::ST_RUNNING;
			cur = 0;
			pid_ctr = 32'd1;
			errors = 0;
		endfunction

		function int find_live(logic [31:0] p);
			int i;
			for (i = 0; i < tsrr_pkg::SLOT_COUNT; i++) begin
				if (pid_q[i] == p && state_q[i] != tsrr_pkg::ST_UNUSED) begin
					return i;
				end
			end
			return tsrr_pkg::SLOT_COUNT;
		endfunction

		function logic [31:0] live_pid();
			int live [$];
			int i;
			for (i = 0; i < tsrr_pkg::SLOT_COUNT; i++) begin
				if (state_q[i] != tsrr_pkg::ST_UNUSED) begin
					live.push_back(i);
				end
			end
			if (live.size() == 0) begin
				return $urandom;
			end
			return pid_q[live[$urandom_range(0, live.size() - 1)]];
		endfunction

		function void apply_command(logic [2:0] op, logic [31:0] tpid, logic [2:0] nst);
			res_word_t w;
			int i;
			int s;
			int idx;
			bit found;
			w = '{tsrr_pkg::RS_OK, tpid, 4'd0, 32'd0};
			case (op)
				tsrr_pkg::CMD_CREATE: begin
					s = tsrr_pkg::SLOT_COUNT;
					for (i = tsrr_pkg::SLOT_COUNT - 1; i >= 1; i--) begin
						if (state_q[i] == tsrr_pkg::ST_UNUSED) s = i;
					end
					if (s == tsrr_pkg::SLOT_COUNT) begin
						w = '{tsrr_pkg::RS_NOSLOT, 32'd0, 4'd0, 32'd0};
					end else begin
						pid_q[s] = pid_ctr;
						pid_ctr = pid_ctr + 32'd1;
						state_q[s] = tsrr_pkg::ST_READY;
						gen_q[s] = gen_q[s] + 32'd1;
						if (gen_q[s] == 32'd0) gen_q[s] = 32'd1;
						entered_q[s] = 1'b0;
						w = '{tsrr_pkg::RS_OK, pid_q[s], 4'(s), gen_q[s]};
					end
				end
				tsrr_pkg::CMD_DESTROY, tsrr_pkg::CMD_ENTER, tsrr_pkg::CMD_SETST: begin
					s = find_live(tpid);
					if (s == tsrr_pkg::SLOT_COUNT) begin
						w = '{tsrr_pkg::RS_NOTFOUND, tpid, 4'd0, 32'd0};
					end else begin
						if (op == tsrr_pkg::CMD_DESTROY) state_q[s] = tsrr_pkg::ST_UNUSED;
						else if (op == tsrr_pkg::CMD_ENTER) entered_q[s] = 1'b1;
						else state_q[s] = nst;
						w = '{tsrr_pkg::RS_OK, tpid, 4'(s), gen_q[s]};
					end
				end
				tsrr_pkg::CMD_PICK: begin
					w = '{tsrr_pkg::RS_OK, 32'd0, 4'd0, gen_q[0]};
					found = 1'b0;
					for (i = 1; i <= tsrr_pkg::SLOT_COUNT; i++) begin
						idx = (cur + i) % tsrr_pkg::SLOT_COUNT;
						if (!found && state_q[idx] == tsrr_pkg::ST_READY &&
							pid_q[idx] != 32'd0 && entered_q[idx]) begin
							found = 1'b1;
							w = '{tsrr_pkg::RS_OK, pid_q[idx], 4'(idx), gen_q[idx]};
						end
					end
				end
				tsrr_pkg::CMD_SWITCH: begin
					s = find_live(tpid);
					if (s == tsrr_pkg::SLOT_COUNT) begin
						w = '{tsrr_pkg::RS_NOTFOUND, tpid, 4'd0, 32'd0};
					end else if ((state_q[s] != tsrr_pkg::ST_READY &&
						state_q[s] != tsrr_pkg::ST_RUNNING) || pid_q[cur] == tpid) begin
						w = '{tsrr_pkg::RS_REFUSED, tpid, 4'(s), gen_q[s]};
					end else begin
						if (state_q[cur] == tsrr_pkg::ST_RUNNING) begin
							state_q[cur] = tsrr_pkg::ST_READY;
						end
						state_q[s] = tsrr_pkg::ST_RUNNING;
						cur = s;
						w = '{tsrr_pkg::RS_OK, tpid, 4'(s), gen_q[s]};
					end
				end
				default: begin
					w = '{tsrr_pkg::RS_OK, tpid, 4'd0, 32'd0};
				end
			endcase
			last_word = w;
			expected_words.push_back(w);
		endfunction

		function void check_result(res_word_t got);
			res_word_t e;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: status %0d pid %h slot %0d gen %h",
					got.status, got.result_pid, got.result_slot, got.result_generation);
				errors++;
				return;
			end
			e = expected_words.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.result_pid !== e.result_pid) begin
				$error("result_pid: expected %h, got %h", e.result_pid, got.result_pid);
				errors++;
			end
			if (got.result_slot !== e.result_slot) begin
				$error("result_slot: expected %0d, got %0d", e.result_slot, got.result_slot);
				errors++;
			end
			if (got.result_generation !== e.result_generation) begin
				$error("result_generation: expected %h, got %h", e.result_generation,
					got.result_generation);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tsrr_cmd_if cmd_ch ();
	tsrr_res_if res_ch ();

	thread_slot_table_round_robin dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	slot_table_tracker tracker;
	int burst_left = 0;
	int items_sent = 0;
	bit hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// present one command word and hold it until accepted
	task automatic send_word(input logic [2:0] op, input logic [31:0] tpid,
		input logic [2:0] nst);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
			gap = $urandom_range(0, 30);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid     <= 1'b1;
		cmd_ch.command   <= op;
		cmd_ch.req_pid   <= tpid;
		cmd_ch.new_state <= nst;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		tracker.apply_command(op, tpid, nst);
		if (op <= tsrr_pkg::CMD_SETST) items_sent++;
	endtask

	// drop valid and wait for every pending result word
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (tracker.expected_words.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			tracker.check_result('{res_ch.status, res_ch.result_pid, res_ch.result_slot,
				res_ch.result_generation});
		end
	end

	initial begin : result_sink
		int mode;
		int left;
		int phase;
		res_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			phase++;
			case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= (phase % 4 == 0);
				default: res_ch.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] p;
		bit held;
		bit drained;
		int n;
		cmd_ch.valid     = 1'b0;
		cmd_ch.command   = tsrr_pkg::CMD_CREATE;
		cmd_ch.req_pid   = '0;
		cmd_ch.new_state = tsrr_pkg::ST_UNUSED;
		held = 1'b0;
		drained = 1'b0;
		tracker = new;
		tracker.reset_table();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(tsrr_pkg::CMD_PICK, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SWITCH, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_DESTROY, 32'hFFFF_FFFF, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_CREATE, 32'hFFFF_FFFF, ST_CODE7);
		p = tracker.last_word.result_pid;
		send_word(tsrr_pkg::CMD_PICK, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_ENTER, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_PICK, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SWITCH, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SWITCH, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SETST, p, ST_BLOCKED);
		send_word(tsrr_pkg::CMD_SWITCH, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SWITCH, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SETST, p, ST_CODE7);
		send_word(tsrr_pkg::CMD_PICK, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(CMD_RSVD6, 32'hFFFF_FFFF, ST_CODE7);
		send_word(CMD_RSVD7, 32'h5A5A_A5A5, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_DESTROY, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_ENTER, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_CREATE, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_CREATE, 32'd0, tsrr_pkg::ST_UNUSED);
		p = tracker.last_word.result_pid;
		send_word(tsrr_pkg::CMD_SWITCH, p, tsrr_pkg::ST_UNUSED);
		// destroy the running thread, then reuse its slot while still current
		send_word(tsrr_pkg::CMD_DESTROY, p, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_CREATE, 32'd0, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SWITCH, tracker.last_word.result_pid, tsrr_pkg::ST_UNUSED);
		send_word(tsrr_pkg::CMD_SWITCH, 32'd0, tsrr_pkg::ST_UNUSED);

		while (items_sent < RANDOM_ITEMS) begin
			if (!held && items_sent >= 400) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!drained && items_sent >= 1000) begin
				drained = 1'b1;
				drain_results();
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send_word(tsrr_pkg::CMD_CREATE, $urandom, 3'($urandom_range(0, 7)));
					if (tracker.last_word.status == tsrr_pkg::RS_OK) begin
						p = tracker.last_word.result_pid;
						send_word(tsrr_pkg::CMD_ENTER, p, 3'($urandom_range(0, 7)));
						if ($urandom_range(0, 1)) begin
							send_word(tsrr_pkg::CMD_PICK, $urandom, 3'd0);
						end
						send_word(tsrr_pkg::CMD_SWITCH, p, 3'($urandom_range(0, 7)));
						send_word(tsrr_pkg::CMD_PICK, $urandom, 3'($urandom_range(0, 7)));
						if ($urandom_range(0, 2) == 0) begin
							send_word(tsrr_pkg::CMD_SETST, p, 3'($urandom_range(0, 7)));
						end
						if ($urandom_range(0, 2) == 0) begin
							send_word(tsrr_pkg::CMD_DESTROY, p, 3'd0);
						end
					end
				end
				4: begin
					send_word(tsrr_pkg::CMD_PICK, tracker.live_pid(), 3'd0);
					send_word(tsrr_pkg::CMD_SWITCH, tracker.last_word.result_pid, 3'd0);
				end
				5, 6: begin
					send_word(3'($urandom_range(0, 5)), tracker.live_pid(),
						3'($urandom_range(0, 7)));
				end
				7: begin
					n = 0;
					do begin
						send_word(tsrr_pkg::CMD_CREATE, $urandom, 3'($urandom_range(0, 7)));
						n++;
					end while (tracker.last_word.status != tsrr_pkg::RS_NOSLOT &&
						n < tsrr_pkg::SLOT_COUNT);
					repeat ($urandom_range(1, 4)) begin
						send_word(tsrr_pkg::CMD_DESTROY, tracker.live_pid(), 3'd0);
					end
				end
				8: begin
					send_word(tsrr_pkg::CMD_DESTROY, tracker.pid_q[tracker.cur], 3'd0);
					send_word(tsrr_pkg::CMD_CREATE, $urandom, 3'd0);
					send_word(tsrr_pkg::CMD_SWITCH, tracker.pid_q[tracker.cur], 3'd0);
					send_word(tsrr_pkg::CMD_SWITCH, tracker.live_pid(), 3'd0);
				end
				default: begin
					send_word(3'($urandom_range(0, 7)), $urandom, 3'($urandom_range(0, 7)));
					if ($urandom_range(0, 29) == 0) drain_results();
				end
			endcase
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
